>>> hw/rtl/largest_empty_square_scan_unit_macros.svh
// Assertion macros shared by the RTL of the largest empty square scan unit.
// Needs no other file; the checks vanish when SYNTHESIS is defined.
`ifndef LARGEST_EMPTY_SQUARE_SCAN_UNIT_MACROS_SVH
`define LARGEST_EMPTY_SQUARE_SCAN_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising edge of clk_i outside reset.
`define LESU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The property must never hold at a rising edge of clk_i outside reset.
`define LESU_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define LESU_ASSERT(lbl, prop, msg)
`define LESU_ASSERT_NEVER(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/lesu_pkg.sv
// Widths, register indexes and pipeline types of the largest empty square scan unit.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package lesu_pkg;

  localparam int MaxWidth = 1024;
  localparam int MaxRows  = 65536;

  localparam int CharW   = 8;
  localparam int ScoreW  = 11;
  localparam int ColW    = $clog2(MaxWidth);
  localparam int RowW    = $clog2(MaxRows);
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 11;

  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};
  localparam logic [RowW-1:0]   RowMax   = RowW'(MaxRows - 1);
  localparam logic [CfgDatW-1:0] WidthMax = CfgDatW'(MaxWidth);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRowWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgObstacle = 2'd1;

  localparam logic [CfgDatW-1:0] RowWidthReset = 11'd1024;
  localparam logic [CharW-1:0]   ObstacleReset = 8'd111;

  // A cell that has been taken in and waits in the score stage.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            blocked;
    logic            edge_cell;
    logic            row_end;
    logic            last;
  } score_req_t;

endpackage

>>> hw/rtl/lesu_cell_if.sv
// Request channel carrying one map cell into the scan unit.
// Depends on lesu_pkg.
`timescale 1ns / 1ps

interface lesu_cell_if;
  logic                       valid;
  logic                       ready;
  logic [lesu_pkg::CharW-1:0] cell_char;
  logic                       last_cell;

  modport source (output valid, output cell_char, output last_cell, input ready);
  modport sink (input valid, input cell_char, input last_cell, output ready);
endinterface

>>> hw/rtl/lesu_best_if.sv
// Result channel carrying the running best square out of the scan unit.
// Depends on lesu_pkg.
`timescale 1ns / 1ps

interface lesu_best_if;
  logic                        valid;
  logic                        ready;
  logic [lesu_pkg::ScoreW-1:0] best_size;
  logic [lesu_pkg::RowW-1:0]   corner_row;
  logic [lesu_pkg::ColW-1:0]   corner_col;
  logic                        map_done;

  modport source (output valid, output best_size, output corner_row, output corner_col,
                  output map_done, input ready);
  modport sink (input valid, input best_size, input corner_row, input corner_col,
                input map_done, output ready);
endinterface

>>> hw/rtl/largest_empty_square_scan_unit.sv
// Largest empty square scan unit: line store, score pipeline and running best.
// Depends on lesu_pkg, lesu_cell_if, lesu_best_if and the assertion macro header.
//
//   channel    dir  payload                                   handshake
//   cell_in    in   cell_char[7:0], last_cell                 valid / ready
//   best_out   out  best_size[10:0], corner_row[15:0],        valid / ready
//                   corner_col[9:0], map_done
//   cfg        in   cfg_idx_i[1:0], cfg_wdata_i[10:0]         cfg_we_i
//
// One cell per cycle is taken in while best_out does not stall; each result goes
// through the score stage and the output register. The rate is set by the single
// line store read issued at request time, whose data is used in the score stage
// on the following cycle. A result waiting in the output register does not block
// a request as long as the score stage is free. Reset clears counters, valid flags
// and best values; the line store needs no clearing as row 0 fills it first.
`timescale 1ns / 1ps
`include "largest_empty_square_scan_unit_macros.svh"

module largest_empty_square_scan_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lesu_cell_if.sink                     cell_in,
  lesu_best_if.source                   best_out,
  input  logic                          cfg_we_i,
  input  logic [lesu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lesu_pkg::CfgDatW-1:0]  cfg_wdata_i
);

  localparam int ColW   = lesu_pkg::ColW;
  localparam int RowW   = lesu_pkg::RowW;
  localparam int ScoreW = lesu_pkg::ScoreW;

  // Configuration registers.
  logic [lesu_pkg::CfgDatW-1:0] row_width_q;
  logic [lesu_pkg::CharW-1:0]   obstacle_q;

  // Request-side counters.
  logic [ColW-1:0] col_count_q, col_count_d;
  logic [RowW-1:0] row_count_q, row_count_d;

  // Score stage.
  logic                    s1_valid_q;
  lesu_pkg::score_req_t    s1_q, s1_d;
  logic [ScoreW-1:0]       up_q;
  logic [ScoreW-1:0]       left_q, diag_q;
  logic [ScoreW-1:0]       top_size_q, top_size_d;
  logic [RowW-1:0]         top_row_q, top_row_d;
  logic [ColW-1:0]         top_col_q, top_col_d;

  // Output register.
  logic              out_valid_q;
  logic [ScoreW-1:0] out_size_q;
  logic [RowW-1:0]   out_row_q;
  logic [ColW-1:0]   out_col_q;
  logic              out_done_q;

  logic [ScoreW-1:0] line_mem [lesu_pkg::MaxWidth];

  logic                         in_fire, s1_fire, fwd;
  logic [lesu_pkg::CfgDatW-1:0] width;
  logic [ColW-1:0]              col;
  logic                         row_end;
  logic [ScoreW-1:0]            least, score;
  logic [ScoreW:0]              inc;

  assign s1_fire       = s1_valid_q && (!out_valid_q || best_out.ready);
  assign cell_in.ready = !s1_valid_q || s1_fire;
  assign in_fire       = cell_in.valid && cell_in.ready;

  // Column of the incoming cell, with the row width clamped to its legal range, and the next counter values.
  always_comb begin
    if (row_width_q == '0) begin
      width = lesu_pkg::CfgDatW'(1);
    end else if (row_width_q > lesu_pkg::WidthMax) begin
      width = lesu_pkg::WidthMax;
    end else begin
      width = row_width_q;
    end
    if (lesu_pkg::CfgDatW'(col_count_q) >= width) begin
      col = ColW'(width - lesu_pkg::CfgDatW'(1));
    end else begin
      col = col_count_q;
    end
    row_end = (lesu_pkg::CfgDatW'(col) + lesu_pkg::CfgDatW'(1)) >= width;

    s1_d.col       = col;
    s1_d.row       = row_count_q;
    s1_d.blocked   = cell_in.cell_char == obstacle_q;
    s1_d.edge_cell = (row_count_q == '0) || (col == '0);
    s1_d.row_end   = row_end;
    s1_d.last      = cell_in.last_cell;

    col_count_d = col_count_q;
    row_count_d = row_count_q;
    if (cell_in.last_cell) begin
      col_count_d = '0;
      row_count_d = '0;
    end else if (row_end) begin
      col_count_d = '0;
      if (row_count_q != lesu_pkg::RowMax) begin
        row_count_d = row_count_q + RowW'(1);
      end
    end else begin
      col_count_d = col + ColW'(1);
    end
  end

  // Score of the cell in the score stage and the updated running best.
  always_comb begin
    least = up_q;
    if (left_q < least) begin
      least = left_q;
    end
    if (diag_q < least) begin
      least = diag_q;
    end
    inc = {1'b0, least} + (ScoreW + 1)'(1);
    if (s1_q.blocked) begin
      score = '0;
    end else if (s1_q.edge_cell) begin
      score = ScoreW'(1);
    end else if (inc > {1'b0, lesu_pkg::ScoreMax}) begin
      score = lesu_pkg::ScoreMax;
    end else begin
      score = inc[ScoreW-1:0];
    end

    top_size_d = top_size_q;
    top_row_d  = top_row_q;
    top_col_d  = top_col_q;
    if (score > top_size_q) begin
      top_size_d = score;
      top_row_d  = s1_q.row;
      top_col_d  = s1_q.col;
    end
  end

  // A write and a read of the same entry in one cycle takes the new score.
  assign fwd = s1_fire && (s1_q.col == col);

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_q.col] <= score;
    end
    if (in_fire) begin
      up_q <= fwd ? score : line_mem[col];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= lesu_pkg::RowWidthReset;
      obstacle_q  <= lesu_pkg::ObstacleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lesu_pkg::CfgRowWidth: row_width_q <= cfg_wdata_i;
        lesu_pkg::CfgObstacle: obstacle_q  <= cfg_wdata_i[lesu_pkg::CharW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        col_count_q <= col_count_d;
        row_count_q <= row_count_d;
      end
      if (cell_in.ready) begin
        s1_valid_q <= cell_in.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      diag_q     <= '0;
      top_size_q <= '0;
      top_row_q  <= '0;
      top_col_q  <= '0;
    end else if (s1_fire) begin
      if (s1_q.last) begin
        left_q     <= '0;
        diag_q     <= '0;
        top_size_q <= '0;
        top_row_q  <= '0;
        top_col_q  <= '0;
      end else begin
        if (s1_q.row_end) begin
          left_q <= '0;
          diag_q <= '0;
        end else begin
          left_q <= score;
          diag_q <= up_q;
        end
        top_size_q <= top_size_d;
        top_row_q  <= top_row_d;
        top_col_q  <= top_col_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (best_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_size_q <= top_size_d;
      out_row_q  <= top_row_d;
      out_col_q  <= top_col_d;
      out_done_q <= s1_q.last;
    end
  end

  assign best_out.valid      = out_valid_q;
  assign best_out.best_size  = out_size_q;
  assign best_out.corner_row = out_row_q;
  assign best_out.corner_col = out_col_q;
  assign best_out.map_done   = out_done_q;

  // Within a map the running best only grows.
  `LESU_ASSERT(a_grow, s1_fire && !s1_q.last |=> top_size_q >= $past(top_size_q), "best shrank")
  // With no square found yet the corner stays at the origin.
  `LESU_ASSERT(a_origin, top_size_q == '0 |-> top_row_q == '0 && top_col_q == '0, "stray corner")
  // A request never overwrites a cell still waiting in the score stage.
  `LESU_ASSERT_NEVER(a_overrun, in_fire && s1_valid_q && !s1_fire, "score stage overrun")
  // A scored cell always lands in the output register.
  `LESU_ASSERT(a_lands, s1_fire |=> out_valid_q, "scored cell lost")

endmodule
